// ===== src/merkle_branch_verify_defines.svh =====
// Assertion macros used by mbv_engine.
`ifndef MERKLE_BRANCH_VERIFY_DEFINES_SVH
`define MERKLE_BRANCH_VERIFY_DEFINES_SVH

`define MBV_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define MBV_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mbv_pkg.sv =====
`default_nettype none
package mbv_pkg;
    localparam int IDX_W = 32;

    typedef enum logic [1:0] {
        OP_LEAF  = 2'd0,
        OP_ROOT  = 2'd1,
        OP_SIB   = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [63:0] word;
        logic [1:0]  pos;
        logic [31:0] idx;
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef logic [31:0] k_arr_t [64];
    localparam k_arr_t SHA_K = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] SHA_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ===== src/merkle_branch_verify.sv =====
`default_nettype none
// Merkle inclusion proof checker with double SHA-256. Load/root/check words
// are taken directly while idle; a sibling's last word (word_pos 3) starts a
// level of three 64-round compressions on one shared round unit, each followed
// by an add step, during which the engine takes no request and the two-entry
// queue ahead of it takes at most two more before s_tready drops.
// The match result sits in an output register and holds the engine until it
// is taken.
module merkle_branch_verify #(
    parameter int INDEX_BITS = mbv_pkg::IDX_W
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,   // op
    input  wire logic [103:0] s_tdata,   // hash_word[63:0], word_pos[65:64], leaf_index[97:66]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata    // match[0]
);
    mbv_pkg::req_t in_req, q_req;
    logic q_valid, q_ready, match;

    always_comb begin
        in_req.op   = mbv_pkg::op_t'(s_tuser);
        in_req.word = s_tdata[63:0];
        in_req.pos  = s_tdata[65:64];
        in_req.idx  = s_tdata[97:66];
    end

    mbv_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_req(in_req),
        .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
    );

    mbv_engine #(.INDEX_BITS(INDEX_BITS)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_match(match)
    );

    assign m_tdata = {7'd0, match};
endmodule
`default_nettype wire

// ===== src/mbv_queue.sv =====
`default_nettype none
module mbv_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire mbv_pkg::req_t in_req,
    output logic               out_valid,
    input  wire logic          out_ready,
    output mbv_pkg::req_t      out_req
);
    mbv_pkg::req_t mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_req   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== src/mbv_engine.sv =====
`default_nettype none
`include "merkle_branch_verify_defines.svh"
module mbv_engine #(
    parameter int INDEX_BITS = mbv_pkg::IDX_W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire mbv_pkg::req_t req,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic               m_match
);
    mbv_pkg::state_t state_reg, state_next;
    logic [255:0] run_reg, run_next;
    logic [255:0] sib_reg, sib_next;
    logic [255:0] root_reg, root_next;
    logic [INDEX_BITS-1:0] path_reg, path_next;
    logic [1:0]   pass_reg, pass_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic [31:0]  w_reg [16];
    logic [31:0]  w_next [16];
    logic [255:0] hs_reg, hs_next;
    logic [255:0] v_reg, v_next;
    logic         match_reg, match_next;
    logic         out_v_reg, out_v_next;

    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, wn;
    logic [511:0] blk;
    logic [255:0] sum;
    logic accept, start_hash;

    assign req_ready = (state_reg == mbv_pkg::ST_IDLE) && !(out_v_reg && !m_tready);
    assign accept    = req_valid && req_ready;
    assign start_hash = accept && req.op == mbv_pkg::OP_SIB && req.pos == 2'd3;
    assign m_tvalid  = out_v_reg;
    assign m_match   = match_reg;

    always_comb begin
        {a, b, c, d, e, f, g, h} = v_reg;
        t1 = h + (mbv_pkg::rotr(e, 6) ^ mbv_pkg::rotr(e, 11) ^ mbv_pkg::rotr(e, 25))
             + ((e & f) ^ (~e & g)) + mbv_pkg::SHA_K[rnd_reg] + w_reg[0];
        t2 = (mbv_pkg::rotr(a, 2) ^ mbv_pkg::rotr(a, 13) ^ mbv_pkg::rotr(a, 22))
             + ((a & b) ^ (a & c) ^ (b & c));
        s0 = mbv_pkg::rotr(w_reg[1], 7) ^ mbv_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = mbv_pkg::rotr(w_reg[14], 17) ^ mbv_pkg::rotr(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        wn = w_reg[0] + s0 + w_reg[9] + s1;
        for (int i = 0; i < 8; i++) begin
            sum[255-32*i -: 32] = hs_reg[255-32*i -: 32] + v_reg[255-32*i -: 32];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mbv_pkg::ST_IDLE:  if (start_hash) state_next = mbv_pkg::ST_ROUND;
            mbv_pkg::ST_ROUND: if (rnd_reg == 6'd63) state_next = mbv_pkg::ST_ADD;
            mbv_pkg::ST_ADD:   state_next = (pass_reg == 2'd2) ? mbv_pkg::ST_IDLE
                                                             : mbv_pkg::ST_ROUND;
            default:           state_next = mbv_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        run_next   = run_reg;
        sib_next   = sib_reg;
        root_next  = root_reg;
        path_next  = path_reg;
        pass_next  = pass_reg;
        rnd_next   = rnd_reg;
        w_next     = w_reg;
        hs_next    = hs_reg;
        v_next     = v_reg;
        match_next = match_reg;
        out_v_next = out_v_reg && !m_tready;
        blk        = '0;
        unique case (state_reg)
            mbv_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (req.op)
                        mbv_pkg::OP_LEAF: begin
                            run_next[255-64*req.pos -: 64] = req.word;
                            if (req.pos == 2'd0) path_next = req.idx[INDEX_BITS-1:0];
                        end
                        mbv_pkg::OP_ROOT: root_next[255-64*req.pos -: 64] = req.word;
                        mbv_pkg::OP_SIB: begin
                            sib_next[255-64*req.pos -: 64] = req.word;
                            if (req.pos == 2'd3) begin
                                blk = path_reg[0] ? {sib_next, run_reg} : {run_reg, sib_next};
                                for (int i = 0; i < 16; i++) w_next[i] = blk[511-32*i -: 32];
                                hs_next   = mbv_pkg::SHA_INIT;
                                v_next    = mbv_pkg::SHA_INIT;
                                pass_next = 2'd0;
                                rnd_next  = 6'd0;
                                path_next = path_reg >> 1;
                            end
                        end
                        default: begin
                            match_next = (run_reg == root_reg);
                            out_v_next = 1'b1;
                        end
                    endcase
                end
            end
            mbv_pkg::ST_ROUND: begin
                v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
                for (int i = 0; i < 15; i++) w_next[i] = w_reg[i+1];
                w_next[15] = wn;
                rnd_next = rnd_reg + 6'd1;
            end
            mbv_pkg::ST_ADD: begin
                rnd_next = 6'd0;
                if (pass_reg == 2'd0) begin
                    hs_next = sum;
                    v_next  = sum;
                    blk     = {32'h80000000, 448'd0, 32'd512};
                end else if (pass_reg == 2'd1) begin
                    hs_next = mbv_pkg::SHA_INIT;
                    v_next  = mbv_pkg::SHA_INIT;
                    blk     = {sum, 32'h80000000, 192'd0, 32'd256};
                end else begin
                    run_next = sum;
                end
                for (int i = 0; i < 16; i++) w_next[i] = blk[511-32*i -: 32];
                pass_next = pass_reg + 2'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        sib_reg   <= sib_next;
        root_reg  <= root_next;
        rnd_reg   <= rnd_next;
        pass_reg  <= pass_next;
        w_reg     <= w_next;
        hs_reg    <= hs_next;
        v_reg     <= v_next;
        match_reg <= match_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mbv_pkg::ST_IDLE;
            run_reg   <= '0;
            path_reg  <= '0;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            run_reg   <= run_next;
            path_reg  <= path_next;
            out_v_reg <= out_v_next;
        end
    end

    `MBV_ASSERT_IMPL(a_busy_no_take, aclk, aresetn, state_reg != mbv_pkg::ST_IDLE, !req_ready, "request taken while hashing")
    `MBV_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_match), "result dropped")
    `MBV_ASSERT_NEXT(a_start, aclk, aresetn, start_hash, state_reg == mbv_pkg::ST_ROUND, "hash did not start")
endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
    typedef logic [3:0][63:0] digest_t;
    typedef logic [31:0] sha_state_t [8];
    typedef logic [31:0] sha_block_t [16];

    typedef struct {
        mbv_pkg::op_t op;
        logic [63:0]  word;
        logic [1:0]   pos;
        logic [31:0]  idx;
        bit           typed;
        bit           match;
    } row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int FLUSH_CYCLES   = 400;
    localparam logic [63:0] ONES  = 64'hffff_ffff_ffff_ffff;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;

    merkle_branch_verify i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    digest_t     chain_hash;
    digest_t     sib_words;
    digest_t     root_words;
    logic [31:0] index_path;
    bit [3:0]    sib_seen;
    bit [3:0]    root_seen;
    bit          expected_match [$];
    int          mismatches;
    int          idle_cycles;
    int          sent_count;
    bit          calm;
    bit          stimulus_done;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic sha_state_t compress(sha_state_t h, sha_block_t blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
        sha_state_t  r;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            w[i] = w[i-16] + w[i-7]
                 + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
        end
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        r[0] = h[0] + a; r[1] = h[1] + b; r[2] = h[2] + c; r[3] = h[3] + d;
        r[4] = h[4] + e; r[5] = h[5] + f; r[6] = h[6] + g; r[7] = h[7] + hh;
        return r;
    endfunction

    function automatic digest_t climb_level(digest_t node, digest_t sib, bit sib_left);
        sha_block_t blk;
        sha_state_t h;
        digest_t    l, r, res;
        l = sib_left ? sib : node;
        r = sib_left ? node : sib;
        for (int i = 0; i < 4; i++) begin
            blk[2*i]     = l[i][63:32];
            blk[2*i+1]   = l[i][31:0];
            blk[8+2*i]   = r[i][63:32];
            blk[8+2*i+1] = r[i][31:0];
        end
        h = compress(IV, blk);
        foreach (blk[i]) blk[i] = '0;
        blk[0]  = 32'h8000_0000;
        blk[15] = 32'd512;
        h = compress(h, blk);
        foreach (blk[i]) blk[i] = '0;
        for (int i = 0; i < 8; i++) blk[i] = h[i];
        blk[8]  = 32'h8000_0000;
        blk[15] = 32'd256;
        h = compress(IV, blk);
        for (int i = 0; i < 4; i++) res[i] = {h[2*i], h[2*i+1]};
        return res;
    endfunction

    task automatic track_request(mbv_pkg::op_t op, logic [63:0] word, logic [1:0] pos,
                                 logic [31:0] idx, bit typed, bit typed_match);
        case (op)
            mbv_pkg::OP_LEAF: begin
                chain_hash[pos] = word;
                if (pos == 2'd0) index_path = idx;
            end
            mbv_pkg::OP_ROOT: begin
                root_words[pos] = word;
                root_seen[pos]  = 1'b1;
            end
            mbv_pkg::OP_SIB: begin
                sib_words[pos] = word;
                sib_seen[pos]  = 1'b1;
                if (pos == 2'd3) begin
                    chain_hash = climb_level(chain_hash, sib_words, index_path[0]);
                    index_path = index_path >> 1;
                end
            end
            default: begin
                expected_match = {expected_match,
                                  bit'(typed ? typed_match : (chain_hash == root_words))};
            end
        endcase
    endtask

    task automatic offer(mbv_pkg::op_t op, logic [63:0] word, logic [1:0] pos,
                         logic [31:0] idx, bit typed = 1'b0, bit typed_match = 1'b0);
        bit taken;
        while (!calm && $urandom_range(99) < 23) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, idx, pos, word};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        track_request(op, word, pos, idx, typed, typed_match);
        sent_count++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [31:0] rand_index();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Load a leaf, a chain of siblings, the root and a check; the root is often the true one.
    task automatic run_proof();
        digest_t     leaf, node, root;
        digest_t     sibs [$];
        logic [31:0] idx, walk;
        int          depth;
        int          order [3];
        int          tmp, j;
        foreach (leaf[i]) leaf[i] = rand_word();
        idx   = rand_index();
        depth = ($urandom_range(59) == 0) ? $urandom_range(36, 33) : $urandom_range(6);
        node  = leaf;
        walk  = idx;
        for (int d = 0; d < depth; d++) begin
            digest_t s;
            foreach (s[i]) s[i] = rand_word();
            sibs = {sibs, s};
            node = climb_level(node, s, walk[0]);
            walk = walk >> 1;
        end
        if ($urandom_range(1)) begin
            root = node;
        end else begin
            foreach (root[i]) root[i] = rand_word();
        end
        offer(mbv_pkg::OP_LEAF, leaf[0], 2'd0, idx);
        for (int i = 1; i < 4; i++) offer(mbv_pkg::OP_LEAF, leaf[i], i[1:0], $urandom);
        foreach (sibs[d]) begin
            order = '{0, 1, 2};
            for (int i = 2; i > 0; i--) begin
                j = $urandom_range(i);
                tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
            for (int i = 0; i < 3; i++)
                offer(mbv_pkg::OP_SIB, sibs[d][order[i]], order[i][1:0], $urandom);
            offer(mbv_pkg::OP_SIB, sibs[d][3], 2'd3, $urandom);
        end
        for (int i = 0; i < 4; i++) offer(mbv_pkg::OP_ROOT, root[i], i[1:0], $urandom);
        offer(mbv_pkg::OP_CHECK, rand_word(), 2'($urandom), $urandom);
    endtask

    task automatic offer_noise();
        mbv_pkg::op_t op;
        logic [1:0]   pos;
        op  = mbv_pkg::op_t'($urandom_range(3));
        pos = 2'($urandom_range(3));
        if (op == mbv_pkg::OP_SIB && pos == 2'd3 && sib_seen[2:0] != 3'b111)
            op = mbv_pkg::OP_LEAF;
        if (op == mbv_pkg::OP_CHECK && root_seen != 4'hf) op = mbv_pkg::OP_ROOT;
        offer(op, rand_word(), pos, rand_index());
    endtask

    initial begin
        row_t rows [$];
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = mbv_pkg::OP_LEAF;
        s_tdata  = '0;
        chain_hash = '0; sib_words = '0; root_words = '0; index_path = '0;
        sib_seen = '0; root_seen = '0;
        mismatches = 0;
        sent_count = 0;
        calm = 1'b0;
        stimulus_done = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows = '{
            '{mbv_pkg::OP_ROOT, ONES, 2'd0, 32'h0, 0, 0},
            '{mbv_pkg::OP_ROOT, ONES, 2'd1, '1, 0, 0},
            '{mbv_pkg::OP_ROOT, ONES, 2'd2, 32'h0, 0, 0},
            '{mbv_pkg::OP_ROOT, ONES, 2'd3, '1, 0, 0},
            '{mbv_pkg::OP_LEAF, ONES, 2'd0, '1, 0, 0},
            '{mbv_pkg::OP_LEAF, ONES, 2'd1, 32'h0, 0, 0},
            '{mbv_pkg::OP_LEAF, ONES, 2'd2, 32'h0, 0, 0},
            '{mbv_pkg::OP_LEAF, ONES, 2'd3, 32'h0, 0, 0},
            '{mbv_pkg::OP_CHECK, ONES, 2'd3, '1, 1, 1},
            '{mbv_pkg::OP_LEAF, 64'h0, 2'd0, 32'h0, 0, 0},
            '{mbv_pkg::OP_CHECK, 64'h0, 2'd0, 32'h0, 1, 0},
            '{mbv_pkg::OP_SIB, 64'h0, 2'd0, '1, 0, 0},
            '{mbv_pkg::OP_SIB, ONES, 2'd1, 32'h0, 0, 0},
            '{mbv_pkg::OP_SIB, 64'h0123_4567_89ab_cdef, 2'd2, 32'h0, 0, 0},
            '{mbv_pkg::OP_SIB, 64'h8000_0000_0000_0001, 2'd3, 32'h0, 0, 0},
            '{mbv_pkg::OP_CHECK, 64'h0, 2'd1, 32'h0, 0, 0},
            '{mbv_pkg::OP_LEAF, 64'h0, 2'd0, 32'h5, 0, 0},
            '{mbv_pkg::OP_SIB, 64'h0, 2'd3, 32'h0, 0, 0},
            '{mbv_pkg::OP_SIB, ONES, 2'd3, 32'h0, 0, 0},
            '{mbv_pkg::OP_SIB, 64'h1, 2'd3, 32'h0, 0, 0},
            '{mbv_pkg::OP_CHECK, ONES, 2'd2, 32'h0, 0, 0}
        };
        foreach (rows[i])
            offer(rows[i].op, rows[i].word, rows[i].pos, rows[i].idx,
                  rows[i].typed, rows[i].match);

        while (sent_count < 1700) begin
            calm = (sent_count > 600 && sent_count < 900);
            if ($urandom_range(9) < 7) begin
                run_proof();
            end else begin
                for (int i = $urandom_range(8, 1); i > 0; i--) offer_noise();
            end
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        stimulus_done = 1'b1;
        while (expected_match.size() != 0) @(posedge aclk);
        repeat (FLUSH_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("merkle_branch_verify verification clean");
        end else begin
            $display("merkle_branch_verify verification failed");
        end
        $finish;
    end

    initial begin
        int hold;
        bit pressed;
        m_tready = 1'b0;
        hold     = 0;
        pressed  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!pressed && expected_match.size() != 0 && $urandom_range(3) == 0) begin
                pressed = 1'b1;
                hold = 1500;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || $urandom_range(99) >= 23;
            end
        end
    end

    always @(negedge aclk) begin
        bit want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_match.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected match result %0d", m_tdata[0]);
            end else begin
                want = expected_match.pop_front();
                if (m_tdata !== {7'd0, want}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("match mismatch: expected %0d, got %h", want, m_tdata);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("merkle_branch_verify verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end
endmodule
`default_nettype wire
